### sv/rpbp_pkg.sv
`timescale 1ns / 1ps

package rpbp_pkg;

  // default sizing
  localparam int NUM_PORTS_DEF   = 4;
  localparam int NUM_HEADERS_DEF = 64;
  localparam int NUM_BUFFERS_DEF = 64;

  // transaction field widths
  localparam int KIND_W   = 3;
  localparam int PORT_W   = 2;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 2;

  // widest index any sizing can need (4096 entries)
  localparam int IDX_MAX_W = 12;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_COPY     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FREE     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DON_HDR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DON_BUF  = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_HDR   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_BUF   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_CNT = 2'd3;

  // free list update commands for one transaction
  typedef struct packed {
    logic hdr_pop;
    logic hdr_push;
    logic buf_pop;
    logic buf_push;
  } list_op_t;

  // reduce a 6-bit field modulo m by shifted compare-subtract
  function automatic logic [IDX_MAX_W-1:0] mod_field(input logic [INDEX_W-1:0] v,
                                                      input logic [IDX_MAX_W:0] m);
    logic [IDX_MAX_W+INDEX_W:0] acc;
    logic [IDX_MAX_W+INDEX_W:0] sh;
    acc = {{(IDX_MAX_W+1){1'b0}}, v};
    for (int i = INDEX_W - 1; i >= 0; i--) begin
      sh = {{INDEX_W{1'b0}}, m} << i;
      if (acc >= sh) begin
        acc = acc - sh;
      end
    end
    return acc[IDX_MAX_W-1:0];
  endfunction

endpackage

### sv/refcounted_packet_buffer_pool.sv
// result: registered in the write-back state, which follows the read state after acceptance
// requests: one at a time, as the header-buffer read and the dependent reference count
//   read both finish before the single write-back state; a push onto a free list takes a
//   further link state to clear the pushed item's link, and a stalled result holds the
//   write-back state
// reset: synchronous active-low; a clear pass over all NUM_BUFFERS entries zeroes the counts
`timescale 1ns / 1ps

module refcounted_packet_buffer_pool #(
  parameter int NUM_PORTS   = rpbp_pkg::NUM_PORTS_DEF,
  parameter int NUM_HEADERS = rpbp_pkg::NUM_HEADERS_DEF,
  parameter int NUM_BUFFERS = rpbp_pkg::NUM_BUFFERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rpbp_pkg::KIND_W-1:0]   in_kind,
  input  logic [rpbp_pkg::PORT_W-1:0]   in_port,
  input  logic [rpbp_pkg::INDEX_W-1:0]  in_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rpbp_pkg::STATUS_W-1:0] out_status,
  output logic [rpbp_pkg::INDEX_W-1:0]  out_header_out,
  output logic [rpbp_pkg::INDEX_W-1:0]  out_buffer_out,
  output logic                          out_buffer_released,
  output logic [rpbp_pkg::PORT_W-1:0]   out_home_port_out
);

  localparam int PW  = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int HW  = $clog2(NUM_HEADERS);
  localparam int BW  = $clog2(NUM_BUFFERS);
  localparam int CW  = $clog2(NUM_HEADERS + 1);
  localparam int HCW = $clog2(NUM_HEADERS + 1);
  localparam int BCW = $clog2(NUM_BUFFERS + 1);

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_RD   = 5'b00100,
    S_WR   = 5'b01000,
    S_LNK  = 5'b10000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [BW-1:0]                clr_idx_r;
  logic [rpbp_pkg::KIND_W-1:0]  kind_r;
  logic [PW-1:0]                port_r;
  logic [HW-1:0]                hidx_r;
  logic [BW-1:0]                bidx_r;
  logic [BW-1:0]                b_r;
  logic                         lnk_hdr_r, lnk_hdr_nxt;
  logic                         lnk_buf_r, lnk_buf_nxt;

  logic                          out_valid_r;
  logic [rpbp_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [HW-1:0]                 out_hdr_r, out_hdr_nxt;
  logic [BW-1:0]                 out_buf_r, out_buf_nxt;
  logic                          out_rel_r, out_rel_nxt;
  logic [PW-1:0]                 out_home_r, out_home_nxt;

  logic          accept, out_free, wr_go, lnk_go;
  logic [PW-1:0] in_p;
  logic [HW-1:0] in_h;
  logic [BW-1:0] in_b;
  logic [BW-1:0] b_sel;
  logic [PW-1:0] hp;

  // list state views
  rpbp_pkg::list_op_t lop;
  logic [PW-1:0]  hdr_sel, buf_sel;
  logic [HW-1:0]  hdr_head, hdr_tail, hdr_push_item;
  logic [HCW-1:0] hdr_cnt;
  logic [BW-1:0]  buf_head, buf_tail, buf_push_item;
  logic [BCW-1:0] buf_cnt;

  // memory ports
  logic          hl_we, hb_we, bl_we, rc_we, hm_we;
  logic [HW-1:0] hl_waddr, hl_wdata, hb_waddr, hl_rdata;
  logic [BW-1:0] hb_wdata, hb_rdata, bl_waddr, bl_wdata, bl_rdata, rc_waddr, hm_waddr;
  logic [CW-1:0] rc_wdata, rc_rdata;
  logic [PW-1:0] hm_wdata, hm_rdata;

  // handshake
  assign accept   = (state_r == S_IDLE) && in_valid;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign wr_go    = (state_r == S_WR) && out_free;
  assign lnk_go   = (state_r == S_LNK);

  // input fields folded into range
  assign in_p = PW'(rpbp_pkg::mod_field(6'(in_port), 13'(NUM_PORTS)));
  assign in_h = HW'(rpbp_pkg::mod_field(in_index, 13'(NUM_HEADERS)));
  assign in_b = BW'(rpbp_pkg::mod_field(in_index, 13'(NUM_BUFFERS)));

  // buffer of the request, known in the read cycle
  assign b_sel = (kind_r == rpbp_pkg::KIND_ALLOC) ? buf_head : hb_rdata;
  assign hp    = hm_rdata;

  // a pushed item ends its list, so its own link is cleared unless it already links to itself
  assign lnk_hdr_nxt = lop.hdr_push && ((hdr_cnt == '0) || (hdr_tail != hidx_r));
  assign lnk_buf_nxt = lop.buf_push && ((buf_cnt == '0) || (buf_tail != buf_push_item));

  // list selection per phase
  always_comb begin
    hdr_sel = port_r;
    buf_sel = port_r;
    if (state_r == S_IDLE) begin
      hdr_sel = in_p;
      buf_sel = in_p;
    end else if (state_r == S_WR && kind_r == rpbp_pkg::KIND_FREE) begin
      buf_sel = hp;
    end
  end

  // state sequencing
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        if (clr_idx_r == BW'(NUM_BUFFERS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RD;
        end
      end
      S_RD:   state_nxt = S_WR;
      S_WR: begin
        if (out_free) begin
          state_nxt = (lnk_hdr_nxt || lnk_buf_nxt) ? S_LNK : S_IDLE;
        end
      end
      S_LNK:  state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_idx_r <= BW'(clr_idx_r + 1'b1);
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      port_r <= in_p;
      hidx_r <= in_h;
      bidx_r <= in_b;
    end
    if (state_r == S_RD) begin
      b_r <= b_sel;
    end
    if (wr_go) begin
      lnk_hdr_r <= lnk_hdr_nxt;
      lnk_buf_r <= lnk_buf_nxt;
    end
  end

  // write-back decision
  always_comb begin
    lop            = '0;
    hdr_push_item  = hidx_r;
    buf_push_item  = b_r;
    hl_we          = 1'b0;
    hl_waddr       = hdr_tail;
    hl_wdata       = hidx_r;
    hb_we          = 1'b0;
    hb_waddr       = hdr_head;
    hb_wdata       = b_r;
    bl_we          = 1'b0;
    bl_waddr       = buf_tail;
    bl_wdata       = b_r;
    rc_we          = 1'b0;
    rc_waddr       = b_r;
    rc_wdata       = rc_rdata;
    hm_we          = 1'b0;
    hm_waddr       = b_r;
    hm_wdata       = port_r;
    out_status_nxt = rpbp_pkg::ST_OK;
    out_hdr_nxt    = '0;
    out_buf_nxt    = '0;
    out_rel_nxt    = 1'b0;
    out_home_nxt   = '0;
    unique case (kind_r)
      rpbp_pkg::KIND_ALLOC: begin
        if (hdr_cnt == '0) begin
          out_status_nxt = rpbp_pkg::ST_NO_HDR;
        end else if (buf_cnt == '0) begin
          out_status_nxt = rpbp_pkg::ST_NO_BUF;
        end else begin
          lop.hdr_pop  = 1'b1;
          lop.buf_pop  = 1'b1;
          hb_we        = 1'b1;
          rc_we        = 1'b1;
          rc_wdata     = CW'(1);
          hm_we        = 1'b1;
          out_hdr_nxt  = hdr_head;
          out_buf_nxt  = b_r;
          out_home_nxt = port_r;
        end
      end
      rpbp_pkg::KIND_COPY: begin
        if (hdr_cnt == '0) begin
          out_status_nxt = rpbp_pkg::ST_NO_HDR;
        end else begin
          lop.hdr_pop  = 1'b1;
          hb_we        = 1'b1;
          rc_we        = 1'b1;
          // count saturates at the header total
          if (rc_rdata < CW'(NUM_HEADERS)) begin
            rc_wdata = CW'(rc_rdata + 1'b1);
          end
          out_hdr_nxt  = hdr_head;
          out_buf_nxt  = b_r;
          out_home_nxt = hm_rdata;
        end
      end
      rpbp_pkg::KIND_FREE: begin
        // header goes back to the requesting port
        if (hdr_cnt != HCW'(NUM_HEADERS)) begin
          lop.hdr_push = 1'b1;
          hl_we        = (hdr_cnt != '0);
        end
        out_buf_nxt  = b_r;
        out_home_nxt = hp;
        if (rc_rdata == '0) begin
          out_status_nxt = rpbp_pkg::ST_ZERO_CNT;
        end else begin
          rc_we    = 1'b1;
          rc_wdata = CW'(rc_rdata - 1'b1);
          // last reference drops: buffer returns to its home port
          if (rc_rdata == CW'(1)) begin
            out_rel_nxt = 1'b1;
            if (buf_cnt != BCW'(NUM_BUFFERS)) begin
              lop.buf_push = 1'b1;
              bl_we        = (buf_cnt != '0);
            end
          end
        end
      end
      rpbp_pkg::KIND_DON_HDR: begin
        if (hdr_cnt != HCW'(NUM_HEADERS)) begin
          lop.hdr_push = 1'b1;
          hl_we        = (hdr_cnt != '0);
        end
      end
      rpbp_pkg::KIND_DON_BUF: begin
        buf_push_item = bidx_r;
        bl_wdata      = bidx_r;
        if (buf_cnt != BCW'(NUM_BUFFERS)) begin
          lop.buf_push = 1'b1;
          bl_we        = (buf_cnt != '0);
        end
      end
      default: begin
        out_status_nxt = rpbp_pkg::ST_OK;
      end
    endcase
  end

  // free list registers
  rpbp_lists #(
    .NUM_PORTS  (NUM_PORTS),
    .NUM_HEADERS(NUM_HEADERS),
    .NUM_BUFFERS(NUM_BUFFERS)
  ) u_lists (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (wr_go ? lop : '0),
    .hdr_sel      (hdr_sel),
    .buf_sel      (buf_sel),
    .hdr_push_item(hdr_push_item),
    .hdr_pop_next (hl_rdata),
    .buf_push_item(buf_push_item),
    .buf_pop_next (bl_rdata),
    .hdr_head     (hdr_head),
    .hdr_tail     (hdr_tail),
    .hdr_cnt      (hdr_cnt),
    .buf_head     (buf_head),
    .buf_tail     (buf_tail),
    .buf_cnt      (buf_cnt)
  );

  // header link memory, tail link in write-back, pushed item's link cleared after
  rpbp_ram #(.DEPTH(NUM_HEADERS), .WIDTH(HW)) u_hdr_link (
    .clk(clk), .we((wr_go && hl_we) || (lnk_go && lnk_hdr_r)),
    .waddr(lnk_go ? hidx_r : hl_waddr), .wdata(lnk_go ? '0 : hl_wdata),
    .re(accept), .raddr(hdr_head), .rdata_r(hl_rdata)
  );

  // header to buffer map
  rpbp_ram #(.DEPTH(NUM_HEADERS), .WIDTH(BW)) u_hdr_buf (
    .clk(clk), .we(wr_go && hb_we), .waddr(hb_waddr), .wdata(hb_wdata),
    .re(accept), .raddr(in_h), .rdata_r(hb_rdata)
  );

  // buffer link memory, same two-step push as the header links
  rpbp_ram #(.DEPTH(NUM_BUFFERS), .WIDTH(BW)) u_buf_link (
    .clk(clk), .we((wr_go && bl_we) || (lnk_go && lnk_buf_r)),
    .waddr(lnk_go ? buf_push_item : bl_waddr), .wdata(lnk_go ? '0 : bl_wdata),
    .re(accept), .raddr(buf_head), .rdata_r(bl_rdata)
  );

  // reference counts, zeroed by the clear pass
  rpbp_ram #(.DEPTH(NUM_BUFFERS), .WIDTH(CW)) u_refcnt (
    .clk  (clk),
    .we   ((state_r == S_CLR) || (wr_go && rc_we)),
    .waddr((state_r == S_CLR) ? clr_idx_r : rc_waddr),
    .wdata((state_r == S_CLR) ? '0 : rc_wdata),
    .re   (state_r == S_RD),
    .raddr(b_sel),
    .rdata_r(rc_rdata)
  );

  // buffer home ports
  rpbp_ram #(.DEPTH(NUM_BUFFERS), .WIDTH(PW)) u_home (
    .clk(clk), .we(wr_go && hm_we), .waddr(hm_waddr), .wdata(hm_wdata),
    .re(state_r == S_RD), .raddr(b_sel), .rdata_r(hm_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wr_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) begin
      out_status_r <= out_status_nxt;
      out_hdr_r    <= out_hdr_nxt;
      out_buf_r    <= out_buf_nxt;
      out_rel_r    <= out_rel_nxt;
      out_home_r   <= out_home_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_header_out      = rpbp_pkg::INDEX_W'(out_hdr_r);
  assign out_buffer_out      = rpbp_pkg::INDEX_W'(out_buf_r);
  assign out_buffer_released = out_rel_r;
  assign out_home_port_out   = rpbp_pkg::PORT_W'(out_home_r);

endmodule

### sv/rpbp_ram.sv
`timescale 1ns / 1ps

module rpbp_ram #(
  parameter int DEPTH = rpbp_pkg::NUM_HEADERS_DEF,
  parameter int WIDTH = rpbp_pkg::INDEX_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### sv/rpbp_lists.sv
`timescale 1ns / 1ps

module rpbp_lists #(
  parameter int NUM_PORTS   = rpbp_pkg::NUM_PORTS_DEF,
  parameter int NUM_HEADERS = rpbp_pkg::NUM_HEADERS_DEF,
  parameter int NUM_BUFFERS = rpbp_pkg::NUM_BUFFERS_DEF,
  localparam int PW  = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1,
  localparam int HW  = $clog2(NUM_HEADERS),
  localparam int BW  = $clog2(NUM_BUFFERS),
  localparam int HCW = $clog2(NUM_HEADERS + 1),
  localparam int BCW = $clog2(NUM_BUFFERS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rpbp_pkg::list_op_t op,
  input  logic [PW-1:0]      hdr_sel,
  input  logic [PW-1:0]      buf_sel,
  input  logic [HW-1:0]      hdr_push_item,
  input  logic [HW-1:0]      hdr_pop_next,
  input  logic [BW-1:0]      buf_push_item,
  input  logic [BW-1:0]      buf_pop_next,
  output logic [HW-1:0]      hdr_head,
  output logic [HW-1:0]      hdr_tail,
  output logic [HCW-1:0]     hdr_cnt,
  output logic [BW-1:0]      buf_head,
  output logic [BW-1:0]      buf_tail,
  output logic [BCW-1:0]     buf_cnt
);

  logic [HW-1:0]  hdr_head_r [NUM_PORTS];
  logic [HW-1:0]  hdr_tail_r [NUM_PORTS];
  logic [HCW-1:0] hdr_cnt_r  [NUM_PORTS];
  logic [BW-1:0]  buf_head_r [NUM_PORTS];
  logic [BW-1:0]  buf_tail_r [NUM_PORTS];
  logic [BCW-1:0] buf_cnt_r  [NUM_PORTS];

  // selected list views
  assign hdr_head = hdr_head_r[hdr_sel];
  assign hdr_tail = hdr_tail_r[hdr_sel];
  assign hdr_cnt  = hdr_cnt_r[hdr_sel];
  assign buf_head = buf_head_r[buf_sel];
  assign buf_tail = buf_tail_r[buf_sel];
  assign buf_cnt  = buf_cnt_r[buf_sel];

  // header list pointers
  always_ff @(posedge clk) begin
    if (op.hdr_push) begin
      if (hdr_cnt == '0) begin
        hdr_head_r[hdr_sel] <= hdr_push_item;
      end
      hdr_tail_r[hdr_sel] <= hdr_push_item;
    end else if (op.hdr_pop) begin
      hdr_head_r[hdr_sel] <= hdr_pop_next;
    end
  end

  // buffer list pointers
  always_ff @(posedge clk) begin
    if (op.buf_push) begin
      if (buf_cnt == '0) begin
        buf_head_r[buf_sel] <= buf_push_item;
      end
      buf_tail_r[buf_sel] <= buf_push_item;
    end else if (op.buf_pop) begin
      buf_head_r[buf_sel] <= buf_pop_next;
    end
  end

  // fill counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        hdr_cnt_r[i] <= '0;
        buf_cnt_r[i] <= '0;
      end
    end else begin
      if (op.hdr_push) begin
        hdr_cnt_r[hdr_sel] <= HCW'(hdr_cnt + 1'b1);
      end else if (op.hdr_pop) begin
        hdr_cnt_r[hdr_sel] <= HCW'(hdr_cnt - 1'b1);
      end
      if (op.buf_push) begin
        buf_cnt_r[buf_sel] <= BCW'(buf_cnt + 1'b1);
      end else if (op.buf_pop) begin
        buf_cnt_r[buf_sel] <= BCW'(buf_cnt - 1'b1);
      end
    end
  end

endmodule

### sv/rpbp_checker.sv
`timescale 1ns / 1ps

module rpbp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rpbp_pkg::STATUS_W-1:0] out_status,
  input logic [rpbp_pkg::INDEX_W-1:0]  out_header_out,
  input logic                          out_buffer_released
);

  // one request in flight: stall rises right after an accepted transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a request is in flight");

  // a released buffer only comes with a successful free
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_buffer_released |-> out_status == rpbp_pkg::ST_OK)
    else $error("buffer released on a failed request");

  // failed requests grant nothing
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rpbp_pkg::ST_OK |->
      out_header_out == '0 && !out_buffer_released)
    else $error("failed request carries a grant");

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_header_out) && $stable(out_buffer_released))
    else $error("stalled result changed");

  // no result straight out of reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind refcounted_packet_buffer_pool rpbp_checker u_rpbp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_header_out     (out_header_out),
  .out_buffer_released(out_buffer_released)
);
